// ===== rtl/core/ihex_pkg.sv =====
// Shared types, codes and helpers for the Intel HEX record parser.
// No dependencies; imported by every module of the block.
package ihex_pkg;

    localparam int CHAR_BITS  = 8;
    localparam int ADDR_OUT_W = 16;
    localparam int KIND_W     = 2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

    typedef enum logic [2:0] {
        PH_COLON = 3'd0,
        PH_LEN   = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5,
        PH_SKIP  = 3'd6
    } t_phase;

    typedef struct packed {
        logic       eol;
        logic       colon;
        logic       hex_ok;
        logic [3:0] nib;
    } t_char_class;

    typedef struct packed {
        logic                  valid;
        logic [KIND_W-1:0]     kind;
        logic [ADDR_OUT_W-1:0] addr;
        logic [7:0]            value;
    } t_result;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

// ===== rtl/core/ihex_char_class.sv =====
// Character classifier: end of line, colon, hex digit and its nibble value.
// Depends on ihex_pkg.
module ihex_char_class (
    input  logic [7:0]           i_char,
    output ihex_pkg::t_char_class o_cls
);
    import ihex_pkg::*;

    logic [4:0] w_hex;

    assign w_hex        = hex_nibble(i_char);
    assign o_cls.eol    = (i_char == CHAR_CR) || (i_char == CHAR_LF);
    assign o_cls.colon  = (i_char == CHAR_COLON);
    assign o_cls.hex_ok = w_hex[4];
    assign o_cls.nib    = w_hex[3:0];

endmodule

// ===== rtl/core/ihex_record_fsm.sv =====
// Record field walker with result register; one character per step.
// Depends on ihex_pkg.
module ihex_record_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_taken,
    input  ihex_pkg::t_char_class i_cls,
    output ihex_pkg::t_result     o_res
);
    import ihex_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_hnh, n_hnh;
    logic [3:0] r_held, n_held;
    logic [7:0] r_len, n_len;
    logic [15:0] r_addr, n_addr;
    logic [7:0] r_kind, n_kind;
    logic [7:0] r_cnt, n_cnt;
    logic       r_done, n_done;
    t_result    r_res, n_res;

    logic [7:0] w_byte;
    logic [7:0] w_cnt_inc;
    logic       w_nib_ok;

    assign w_byte    = {r_held, i_cls.nib};
    assign w_cnt_inc = r_cnt + 8'd1;
    // the current character is a hex digit; with a held high nibble it completes a byte
    assign w_nib_ok  = !i_cls.eol && i_cls.hex_ok;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hnh   = r_hnh;
        n_held  = r_held;
        n_len   = r_len;
        n_addr  = r_addr;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        n_done  = r_done;
        if (!r_done) begin
            case (r_phase)
                PH_COLON: begin
                    if (i_cls.colon) begin
                        n_phase = PH_LEN;
                        n_hnh   = 1'b0;
                        n_held  = 4'd0;
                        n_cnt   = 8'd0;
                    end else if (!i_cls.eol) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_cls.eol) n_phase = PH_COLON;
                end
                PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
                    if (i_cls.eol) begin
                        n_phase = PH_COLON;
                        n_hnh   = 1'b0;
                    end else if (!i_cls.hex_ok) begin
                        n_phase = PH_SKIP;
                        n_hnh   = 1'b0;
                    end else if (!r_hnh) begin
                        n_held = i_cls.nib;
                        n_hnh  = 1'b1;
                    end else begin
                        n_hnh = 1'b0;
                        case (r_phase)
                            PH_LEN: begin
                                n_len   = w_byte;
                                n_addr  = 16'd0;
                                n_cnt   = 8'd0;
                                n_phase = PH_ADDR;
                            end
                            PH_ADDR: begin
                                n_addr = {r_addr[7:0], w_byte};
                                n_cnt  = w_cnt_inc;
                                if (w_cnt_inc >= 8'd2) begin
                                    n_cnt   = 8'd0;
                                    n_phase = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                n_kind  = w_byte;
                                n_cnt   = 8'd0;
                                n_phase = (r_len == 8'd0) ? PH_CSUM : PH_DATA;
                                if (w_byte == REC_EOF) n_done = 1'b1;
                            end
                            PH_DATA: begin
                                n_cnt = w_cnt_inc;
                                if (w_cnt_inc >= r_len) n_phase = PH_CSUM;
                            end
                            default: n_phase = PH_SKIP;
                        endcase
                    end
                end
                default: begin
                    if (i_cls.eol) n_phase = PH_COLON;
                end
            endcase
        end
    end

    // result for this character
    always_comb begin
        n_res = '0;
        if (!r_done) begin
            case (r_phase)
                PH_COLON: begin
                    if (!i_cls.eol && !i_cls.colon) begin
                        n_res.valid = 1'b1;
                        n_res.kind  = KIND_BAD;
                    end
                end
                PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
                    if (!i_cls.eol && !i_cls.hex_ok) begin
                        n_res.valid = 1'b1;
                        n_res.kind  = KIND_BAD;
                    end else if (w_nib_ok && r_hnh) begin
                        if (r_phase == PH_TYPE && w_byte == REC_EOF) begin
                            n_res.valid = 1'b1;
                            n_res.kind  = KIND_EOF;
                        end else if (r_phase == PH_DATA && r_kind == REC_DATA) begin
                            n_res.valid = 1'b1;
                            n_res.kind  = KIND_DATA;
                            n_res.addr  = r_addr + {8'd0, r_cnt};
                            n_res.value = w_byte;
                        end
                    end
                end
                default: n_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COLON;
            r_hnh   <= 1'b0;
            r_held  <= 4'd0;
            r_len   <= 8'd0;
            r_addr  <= 16'd0;
            r_kind  <= 8'd0;
            r_cnt   <= 8'd0;
            r_done  <= 1'b0;
            r_res   <= '0;
        end else begin
            if (i_step) begin
                r_phase <= n_phase;
                r_hnh   <= n_hnh;
                r_held  <= n_held;
                r_len   <= n_len;
                r_addr  <= n_addr;
                r_kind  <= n_kind;
                r_cnt   <= n_cnt;
                r_done  <= n_done;
                r_res   <= n_res;
            end else if (i_taken) begin
                r_res.valid <= 1'b0;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/intel_hex_record_parser.sv =====
// Intel HEX record parser, top level: input register and stream handshake.
// The accepted character is held in the input register, then its result in the result register.
// Throughput: one character per cycle, limited only by master-side backpressure.
// Reset (i_rst_n low, synchronous) returns to waiting for a colon and empties
// both the input register and the result register.
// Depends on ihex_pkg, ihex_char_class, ihex_record_fsm.
module intel_hex_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] byte_address, [23:16] byte_value
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import ihex_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        w_step;
    logic        w_taken;
    t_char_class w_cls;
    t_result     w_res;

    assign w_taken  = w_res.valid && m_tready;
    assign w_step   = r_in_valid && (!w_res.valid || m_tready);
    assign s_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) r_in_char <= s_tdata;
    end

    ihex_char_class u_cls (
        .i_char (r_in_char),
        .o_cls  (w_cls)
    );

    ihex_record_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_taken (w_taken),
        .i_cls   (w_cls),
        .o_res   (w_res)
    );

    assign m_tvalid = w_res.valid;
    assign m_tdata  = {w_res.value, w_res.addr};
    assign m_tuser  = w_res.kind;

endmodule

// ===== rtl/core/ihex_checker.sv =====
// Port-level checker for the Intel HEX record parser, bound to the top level.
// Depends on ihex_pkg.
module ihex_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ihex_pkg::*;

    logic r_eof_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_seen <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser == KIND_EOF) begin
            r_eof_seen <= 1'b1;
        end
    end

    // nothing follows the end-of-file request
    a_no_result_after_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eof_seen |-> !m_tvalid)
        else $error("result after end of file");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_EOF || m_tuser == KIND_BAD))
        else $error("illegal result kind");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata == 24'd0))
        else $error("non-data result carries payload");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);
